>>> hdl/ttb_pkg.sv
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int unsigned CALIB_TICKS = 10;
    localparam int unsigned TALLY_W = 4;
    localparam logic [TALLY_W-1:0] CALIB_TALLY_END = TALLY_W'(CALIB_TICKS);

    localparam logic [31:0] RATE_RESET = 32'd1000;
    localparam logic [31:0] SCALE_1000 = 32'd1000;
    localparam logic [63:0] CALIB_US_NUM = 64'(CALIB_TICKS) * 64'd1000000;
    localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;

    localparam int unsigned DIV_W = 64;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_CALIB    = 3'd1,
        OP_READ     = 3'd2,
        OP_UPTIME   = 3'd3,
        OP_US_SINCE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_COUNT = 2'd2
    } calib_phase_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_POST  = 6'b001000,
        S_SCALE = 6'b010000,
        S_DONE  = 6'b100000
    } seq_state_t;

    typedef enum logic [2:0] {
        JOB_UPTIME    = 3'd0,
        JOB_UPTIME_US = 3'd1,
        JOB_CAL_US    = 3'd2,
        JOB_CAL_CPU   = 3'd3,
        JOB_ELAPSED   = 3'd4
    } div_job_t;

endpackage

>>> hdl/tick_timebase_with_tsc_calibration.sv
`timescale 1ns / 1ps

// channel  direction  ports                 payload
// s_       in         s_valid s_ready       opcode, cycle stamp, start stamp
// m_       out        m_valid m_ready       result value, calibrated flag
// cfg_     in         cfg_valid cfg_ready   tick rate in hz
//
// tick, calibrate arm, read ticks and unused opcodes go straight from idle to the done step
// uptime ms and us since make one pass of the 64-step shared divider
// the tick that ends a calibration run makes up to two divider passes
// synchronous active-low reset; rate returns to 1000 hz, block uncalibrated
// s_ready is low while an item is in work; a held result stalls only the item behind it

module tick_timebase_with_tsc_calibration
    import ttb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [63:0] s_cycle_stamp_now,
    input  logic [63:0] s_start_stamp,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_is_calibrated,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_tick_rate_hz
);

    seq_state_t           state_reg, state_next;
    div_job_t             job_reg, job_next;
    calib_phase_t         phase_reg, phase_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;
    logic [31:0]          rate_reg, rate_next;
    logic [31:0]          count_reg, count_next;
    logic [63:0]          first_reg, first_next;
    logic [63:0]          cpu_reg, cpu_next;
    logic [63:0]          now_reg, now_next;

    logic [63:0]          rem_reg, rem_next;
    logic [63:0]          quo_reg, quo_next;
    logic [63:0]          divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [31:0]          res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_result_reg, m_result_next;
    logic                 m_cal_reg, m_cal_next;

    logic                 s_fire;
    logic [64:0]          trial;
    logic [64:0]          diff;
    logic                 fits;
    logic [31:0]          mul_src;
    logic [31:0]          mul_prod;
    logic [TALLY_W-1:0]   tally_inc;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_result_value  = m_result_reg;
    assign m_is_calibrated = m_cal_reg;

    // shared restoring divider step
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    // shared constant multiplier
    assign mul_src  = (state_reg == S_MUL) ? count_reg : quo_reg[31:0];
    assign mul_prod = mul_src * SCALE_1000;

    assign tally_inc = tally_reg + TALLY_W'(1);

    always_comb begin
        state_next    = state_reg;
        job_next      = job_reg;
        phase_next    = phase_reg;
        tally_next    = tally_reg;
        rate_next     = rate_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        cpu_next      = cpu_reg;
        now_next      = now_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        divisor_next  = divisor_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        m_cal_next    = m_cal_reg;

        if (cfg_valid && cfg_ready) begin
            rate_next = cfg_tick_rate_hz;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    now_next   = s_cycle_stamp_now;
                    res_next   = '0;
                    state_next = S_DONE;
                    rem_next   = '0;
                    cnt_next   = '0;
                    unique case (s_opcode)
                        OP_TICK: begin
                            count_next = count_reg + 32'd1;
                            res_next   = count_reg + 32'd1;
                            priority if (phase_reg == PH_WAIT) begin
                                first_next = s_cycle_stamp_now;
                                tally_next = '0;
                                phase_next = PH_COUNT;
                            end else if (phase_reg == PH_COUNT) begin
                                tally_next = tally_inc;
                                if (tally_inc >= CALIB_TALLY_END) begin
                                    phase_next = PH_IDLE;
                                    if (s_cycle_stamp_now > first_reg && rate_reg != '0) begin
                                        quo_next     = CALIB_US_NUM;
                                        divisor_next = {32'd0, rate_reg};
                                        job_next     = JOB_CAL_US;
                                        state_next   = S_DIV;
                                    end
                                end
                            end else begin
                            end
                        end
                        OP_CALIB: begin
                            if (rate_reg != '0) begin
                                phase_next = PH_WAIT;
                                tally_next = '0;
                            end
                        end
                        OP_READ: begin
                            res_next = count_reg;
                        end
                        OP_UPTIME: begin
                            if (rate_reg != '0) begin
                                job_next   = JOB_UPTIME;
                                state_next = S_MUL;
                            end
                        end
                        OP_US_SINCE: begin
                            priority if (cpu_reg == '0) begin
                                if (rate_reg != '0) begin
                                    job_next   = JOB_UPTIME_US;
                                    state_next = S_MUL;
                                end
                            end else if (s_cycle_stamp_now >= s_start_stamp) begin
                                quo_next     = s_cycle_stamp_now - s_start_stamp;
                                divisor_next = cpu_reg;
                                job_next     = JOB_ELAPSED;
                                state_next   = S_DIV;
                            end else begin
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MUL: begin
                rem_next     = '0;
                quo_next     = {32'd0, mul_prod};
                divisor_next = {32'd0, rate_reg};
                cnt_next     = '0;
                state_next   = S_DIV;
            end

            S_DIV: begin
                rem_next = fits ? diff[63:0] : trial[63:0];
                quo_next = {quo_reg[62:0], fits};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_POST;
                end
            end

            S_POST: begin
                state_next = S_DONE;
                unique case (job_reg)
                    JOB_UPTIME: begin
                        res_next = quo_reg[31:0];
                    end
                    JOB_UPTIME_US: begin
                        state_next = S_SCALE;
                    end
                    JOB_CAL_US: begin
                        if (quo_reg != '0) begin
                            rem_next     = '0;
                            quo_next     = now_reg - first_reg;
                            divisor_next = quo_reg;
                            cnt_next     = '0;
                            job_next     = JOB_CAL_CPU;
                            state_next   = S_DIV;
                        end
                    end
                    JOB_CAL_CPU: begin
                        cpu_next = quo_reg;
                    end
                    JOB_ELAPSED: begin
                        res_next = (quo_reg[63:32] != '0) ? SAT_VALUE : quo_reg[31:0];
                    end
                    default: begin
                    end
                endcase
            end

            S_SCALE: begin
                res_next   = mul_prod;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_result_next = res_reg;
                    m_cal_next    = (cpu_reg != '0);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            job_reg     <= JOB_UPTIME;
            phase_reg   <= PH_IDLE;
            tally_reg   <= '0;
            rate_reg    <= RATE_RESET;
            count_reg   <= '0;
            first_reg   <= '0;
            cpu_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            phase_reg   <= phase_next;
            tally_reg   <= tally_next;
            rate_reg    <= rate_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            cpu_reg     <= cpu_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        divisor_reg  <= divisor_next;
        res_reg      <= res_next;
        m_result_reg <= m_result_next;
        m_cal_reg    <= m_cal_next;
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_no_div_by_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (divisor_reg != '0))
        else $error("divider running with zero divisor");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done step");

    a_tally_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= CALIB_TALLY_END)
        else $error("calibration tally past run length");
`endif

endmodule
